// File: hw/rtl/psrhq_pkg.sv
`default_nettype none

package psrhq_pkg;

  // field widths of the request and response items
  localparam int COORD_W    = 16;
  localparam int RADIUS_W   = 15;
  localparam int RR_W       = 2 * RADIUS_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int POINT_W    = 2 * COORD_W;
  localparam int COUNT_W    = 11;
  localparam int CMD_W      = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = 4 * COORD_W + RADIUS_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_CIRCLE = 2'd3
  } cmd_e;

  // query handed to the scan engine
  typedef struct packed {
    logic                      is_circle;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic        [RR_W-1:0]    rr;
  } query_t;

  // scan engine result
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/psrhq_ram.sv
`default_nettype none

module psrhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/psrhq_scan.sv
`default_nettype none

module psrhq_scan #(
  parameter int CNT_W  = 11,
  parameter int ADDR_W = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire psrhq_pkg::query_t               query_i,
  input  wire logic [CNT_W-1:0]                count_i,
  output logic                                 rd_en_o,
  output logic [ADDR_W-1:0]                    rd_addr_o,
  input  wire logic [psrhq_pkg::POINT_W-1:0]   rd_data_i,
  output psrhq_pkg::scan_res_t                 res_o
);

  import psrhq_pkg::*;

  query_t                    qry_q;
  logic                      busy_q;
  logic                      active_q;
  logic [CNT_W-1:0]          idx_q;
  logic [CNT_W-1:0]          idx_nxt;
  logic                      s0_q;
  logic                      v1_q;
  logic                      v2_q;
  logic                      hit_q;
  logic                      box1_q;
  logic                      box2_q;
  logic signed [DIFF_W-1:0]  dx1_q;
  logic signed [DIFF_W-1:0]  dy1_q;
  logic        [SQ_W-1:0]    sqx_q;
  logic        [SQ_W-1:0]    sqy_q;

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic                      box_in;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic        [SUM_W-1:0]   dist_sq;
  logic                      circ_in;
  logic                      done;

  // address sequencer over the held points
  assign idx_nxt   = idx_q + 1'b1;
  assign rd_en_o   = active_q;
  assign rd_addr_o = idx_q[ADDR_W-1:0];

  // stage 1: box bounds and coordinate differences
  assign px     = rd_data_i[COORD_W-1:0];
  assign py     = rd_data_i[POINT_W-1:COORD_W];
  assign box_in = (px >= qry_q.ax) && (px <= qry_q.bx) &&
                  (py >= qry_q.ay) && (py <= qry_q.by);
  assign dx     = {px[COORD_W-1], px} - {qry_q.ax[COORD_W-1], qry_q.ax};
  assign dy     = {py[COORD_W-1], py} - {qry_q.ay[COORD_W-1], qry_q.ay};

  // stage 2: squares
  assign prod_x = dx1_q * dx1_q;
  assign prod_y = dy1_q * dy1_q;

  // stage 3: distance compare
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign circ_in = dist_sq <= {{(SUM_W - RR_W){1'b0}}, qry_q.rr};

  assign done  = busy_q && !active_q && !s0_q && !v1_q && !v2_q;
  assign res_o = '{done: done, hit: hit_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      active_q <= 1'b0;
      idx_q    <= '0;
      s0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      s0_q <= active_q;
      v1_q <= s0_q;
      v2_q <= v1_q;
      if (start_i) begin
        busy_q   <= 1'b1;
        active_q <= (count_i != '0);
        idx_q    <= '0;
        hit_q    <= 1'b0;
      end else begin
        if (done) begin
          busy_q <= 1'b0;
        end
        if (active_q) begin
          idx_q <= idx_nxt;
          if (idx_nxt == count_i) begin
            active_q <= 1'b0;
          end
        end
        if (v2_q) begin
          hit_q <= hit_q | (qry_q.is_circle ? circ_in : box2_q);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qry_q <= query_i;
    end
    box1_q <= box_in;
    dx1_q  <= dx;
    dy1_q  <= dy;
    box2_q <= box1_q;
    sqx_q  <= prod_x[SQ_W-1:0];
    sqy_q  <= prod_y[SQ_W-1:0];
  end

  // reads stay below the fill count
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (idx_q < count_i))
    else $error("scan read beyond held points");

  // no new query while one is in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("scan started while busy");

  // a finished scan reports for one cycle only
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("scan done held over two cycles");

endmodule

`default_nettype wire

// File: hw/rtl/point_set_region_hit_query.sv
`default_nettype none

// Point store with box and circle hit queries. Each request (cmd in tuser)
// gives one response. Clear and load set the response register in the cycle
// after the request is taken; a box or circle query reads the held points one
// per cycle from the single read port of the point memory and passes them
// through a three-stage compare pipeline, and its response is registered once
// the scan is done. A new request is taken at the earliest in the cycle in
// which the previous response leaves the output register, and never during a
// query scan. A load into a full store is dropped and reported with status 1.
// Memory contents need no clearing after reset.
module point_set_region_hit_query #(
  parameter int POINTS_MAX = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // coord_a_x, coord_a_y, coord_b_x, coord_b_y, radius, zero pad
  input  wire logic [psrhq_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // cmd
  input  wire logic [psrhq_pkg::CMD_W-1:0]         s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // hit, status, stored_count, zero pad
  output logic [psrhq_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);

  import psrhq_pkg::*;

  localparam int ADDR_W = (POINTS_MAX > 1) ? $clog2(POINTS_MAX) : 1;
  localparam int CNT_W  = $clog2(POINTS_MAX + 1);
  localparam int PAD_W  = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic                      out_valid_q;
  logic                      out_hit_q;
  logic                      out_status_q;

  cmd_e                      cmd;
  logic signed [COORD_W-1:0] ax;
  logic signed [COORD_W-1:0] ay;
  logic signed [COORD_W-1:0] bx;
  logic signed [COORD_W-1:0] by;
  logic        [RADIUS_W-1:0] radius;
  logic                      accept;
  logic                      full;
  logic                      ram_we;
  logic                      start;
  query_t                    query;
  scan_res_t                 scan_res;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [POINT_W-1:0]        rd_data;
  logic [CNT_W+COUNT_W-1:0]  count_ext;

  // request fields
  assign cmd    = cmd_e'(s_axis_tuser_i);
  assign ax     = s_axis_tdata_i[COORD_W-1:0];
  assign ay     = s_axis_tdata_i[2*COORD_W-1:COORD_W];
  assign bx     = s_axis_tdata_i[3*COORD_W-1:2*COORD_W];
  assign by     = s_axis_tdata_i[4*COORD_W-1:3*COORD_W];
  assign radius = s_axis_tdata_i[4*COORD_W+RADIUS_W-1:4*COORD_W];

  // handshake
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(POINTS_MAX));

  // load writes at the fill count, queries start the scan
  assign ram_we = accept && (cmd == CMD_LOAD) && !full;
  assign start  = accept && ((cmd == CMD_BOX) || (cmd == CMD_CIRCLE));

  assign query = '{
    is_circle: (cmd == CMD_CIRCLE),
    ax:        ax,
    ay:        ay,
    bx:        bx,
    by:        by,
    rr:        radius * radius
  };

  psrhq_ram #(
    .WIDTH (POINT_W),
    .DEPTH (POINTS_MAX),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i({ay, ax}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  psrhq_scan #(
    .CNT_W (CNT_W),
    .ADDR_W(ADDR_W)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .query_i  (query),
    .count_i  (count_q),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .res_o    (scan_res)
  );

  // request sequencing, fill count and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_CLEAR: begin
                count_q      <= '0;
                out_valid_q  <= 1'b1;
                out_hit_q    <= 1'b0;
                out_status_q <= 1'b0;
              end
              CMD_LOAD: begin
                if (!full) begin
                  count_q <= count_q + 1'b1;
                end
                out_valid_q  <= 1'b1;
                out_hit_q    <= 1'b0;
                out_status_q <= full;
              end
              CMD_BOX, CMD_CIRCLE: begin
                state_q <= ST_SCAN;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            out_valid_q  <= 1'b1;
            out_hit_q    <= scan_res.hit;
            out_status_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // response packing
  assign count_ext       = {{COUNT_W{1'b0}}, count_q};
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, count_ext[COUNT_W-1:0], out_status_q, out_hit_q};

  // a finished scan always finds the response register free
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == ST_SCAN) && !out_valid_q)
    else $error("scan result with response register occupied");

  // fill count never passes capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POINTS_MAX))
    else $error("fill count above capacity");

  // a query request moves into the scan and holds the count
  a_query_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_SCAN) && $stable(count_q))
    else $error("query did not enter scan");

endmodule

`default_nettype wire
